// ===== sv/lmhd_pkg.sv =====
// Shared types, codes and the byte-wise CRC-32 step for the history decoder.
// Used by the CRC unit, the top level and the bench; depends on nothing else.
package lmhd_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_BAD_OFFSET   = 2'd1;
  localparam logic [1:0] STAT_ZERO_LEN     = 2'd2;
  localparam logic [1:0] STAT_CRC_MISMATCH = 2'd3;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MRD,
    S_MCP
  } state_t;

  typedef struct packed {
    logic       upd;
    logic       clr;
    logic [7:0] data;
  } crc_ctl_t;

  // One byte through the reflected CRC-32, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/literal_match_history_decoder_unit.sv =====
// A literal, a rejected match or a chunk end passes from S_IDLE through S_EXEC into the output
// register; a match passes through S_MRD and S_MCP. A new item is accepted only in S_IDLE, once
// the last one is done. The single read port of the history memory supplies one copied byte
// per cycle while the output is not stalled.
// Reset clears the sequencer, write pointer, byte count, CRC and output valid, and sets the
// check enable to 1; the history memory is not cleared.
module literal_match_history_decoder_unit import lmhd_pkg::*; #(
  parameter int HISTORY_DEPTH = 65536,
  parameter int MAX_MATCH     = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // data_byte[7:0], match_length[14:8],
                                 // match_offset[30:15], stored_checksum[62:31], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte[7:0], running_checksum[39:8]
  output logic [2:0]  m_tuser,   // byte_valid[0], status[2:1]
  output logic        m_tlast,   // last
  // Configuration: crc_check_enable.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW = (CW > 16) ? CW : 16;
  localparam int LW   = $clog2(MAX_MATCH + 1);

  // Input fields.
  logic [7:0]  in_byte;
  logic [6:0]  in_len;
  logic [15:0] in_off;
  logic [31:0] in_stored;
  assign in_byte   = s_tdata[7:0];
  assign in_len    = s_tdata[14:8];
  assign in_off    = s_tdata[30:15];
  assign in_stored = s_tdata[62:31];

  // Control state.
  state_t      state, state_next;
  logic [AW-1:0] wp;
  logic [CW-1:0] produced;
  logic          crc_en;

  // Item registers, loaded on an input transfer.
  logic [1:0]    op_kind;
  logic [7:0]    op_byte;
  logic [1:0]    op_status;
  logic [31:0]   op_stored;
  logic [AW-1:0] src;
  logic [LW-1:0] remaining;

  // Bypass for a read that hits the address written in the same cycle.
  logic          fwd;
  logic [7:0]    fwd_byte;

  logic          in_xfer;
  logic          out_free;
  logic          out_load;
  logic          mem_we;
  logic          mem_re;
  logic [7:0]    mem_rdata;
  logic [7:0]    copy_byte;
  logic [7:0]    emit_byte;
  logic          last_one;
  logic [31:0]   crc;
  logic [31:0]   crc_upd;
  crc_ctl_t      crc_ctl;

  // Offset check and source address, computed during the input transfer.
  logic [CMPW-1:0] off_x;
  logic [CMPW-1:0] prod_x;
  logic            bad_off;
  logic [CMPW:0]   wp_x;
  logic [CMPW:0]   off_w;
  logic [CMPW:0]   src_x;
  logic [1:0]      in_status;
  logic [LW-1:0]   in_len_sat;
  logic [AW-1:0]   src_inc;
  logic [AW-1:0]   wp_inc;

  // Result fields before the output register.
  logic [7:0]  res_byte;
  logic        res_valid;
  logic        res_last;
  logic [1:0]  res_status;
  logic [31:0] res_crc;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign last_one  = (remaining == LW'(1));

  assign off_x   = CMPW'(in_off);
  assign prod_x  = CMPW'(produced);
  assign bad_off = (off_x == '0) || (off_x > prod_x);

  // Offset is at most the window here, so one conditional add wraps it.
  assign wp_x  = (CMPW + 1)'(wp);
  assign off_w = (CMPW + 1)'(in_off);
  assign src_x = (wp_x >= off_w) ? (wp_x - off_w)
                                 : (wp_x + (CMPW + 1)'(HISTORY_DEPTH) - off_w);

  always_comb begin
    if (bad_off) begin
      in_status = STAT_BAD_OFFSET;
    end else if (in_len == 7'd0) begin
      in_status = STAT_ZERO_LEN;
    end else begin
      in_status = STAT_OK;
    end
  end

  assign in_len_sat = (in_len > 7'(MAX_MATCH)) ? LW'(MAX_MATCH) : LW'(in_len);
  assign src_inc    = (src == AW'(HISTORY_DEPTH - 1)) ? '0 : src + AW'(1);
  assign wp_inc     = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + AW'(1);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            KIND_LIT:   state_next = S_EXEC;
            KIND_MATCH: state_next = (in_status == STAT_OK) ? S_MRD : S_EXEC;
            KIND_END:   state_next = S_EXEC;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      S_MRD: begin
        state_next = S_MCP;
      end
      S_MCP: begin
        if (out_free && last_one) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer. Every byte written to history is also emitted.
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_EXEC: begin
        out_load = out_free;
        mem_we   = out_free && (op_kind == KIND_LIT);
      end
      S_MRD: begin
        mem_re = 1'b1;
      end
      S_MCP: begin
        out_load = out_free;
        mem_we   = out_free;
        mem_re   = out_free && !last_one;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  assign copy_byte = fwd ? fwd_byte : mem_rdata;
  assign emit_byte = (state == S_MCP) ? copy_byte : op_byte;

  assign crc_ctl.upd  = mem_we;
  assign crc_ctl.clr  = out_load && (state == S_EXEC) && (op_kind == KIND_END);
  assign crc_ctl.data = emit_byte;

  // Result fields. A chunk end reports the CRC it compared, before the clear.
  always_comb begin
    res_byte  = mem_we ? emit_byte : 8'd0;
    res_valid = mem_we;
    res_last  = (state == S_MCP) ? last_one : 1'b1;
    res_crc   = mem_we ? crc_upd : crc;
    if (state == S_EXEC && op_kind == KIND_END) begin
      res_status = (crc_en && (crc != op_stored)) ? STAT_CRC_MISMATCH : STAT_OK;
    end else if (state == S_EXEC) begin
      res_status = op_status;
    end else begin
      res_status = STAT_OK;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      produced <= '0;
      crc_en   <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) crc_en <= cfg_data;
      if (mem_we) begin
        wp <= wp_inc;
        if (produced != CW'(HISTORY_DEPTH)) produced <= produced + CW'(1);
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item and copy registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_kind   <= s_tuser;
      op_byte   <= in_byte;
      op_stored <= in_stored;
      op_status <= (s_tuser == KIND_MATCH) ? in_status : STAT_OK;
      src       <= AW'(src_x);
      remaining <= in_len_sat;
    end
    if (mem_re) begin
      src      <= src_inc;
      fwd      <= mem_we && (src == wp);
      fwd_byte <= copy_byte;
    end
    if (state == S_MCP && mem_we) begin
      remaining <= remaining - LW'(1);
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res_crc, res_byte};
      m_tuser <= {res_status, res_valid};
      m_tlast <= res_last;
    end
  end

  lmhd_history_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp),
    .wdata (emit_byte),
    .re    (mem_re),
    .raddr (src),
    .rdata (mem_rdata)
  );

  lmhd_crc_unit u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (crc_ctl),
    .crc     (crc),
    .crc_upd (crc_upd)
  );

  // The byte count never passes the window size.
  a_produced_sat: assert property (@(posedge clk) disable iff (rst)
    produced <= CW'(HISTORY_DEPTH))
    else $error("byte count passed the window size");

  // A copy in progress always has bytes left to emit.
  a_copy_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == S_MRD || state == S_MCP) |-> remaining != '0)
    else $error("copy running with no bytes left");

  // A history write only happens together with a result transfer into the output register.
  a_write_emits: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> out_load)
    else $error("history written without a result");

  // The CRC is zero right after a chunk-end result is produced.
  a_crc_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_load && state == S_EXEC && op_kind == KIND_END) |=> crc == 32'd0)
    else $error("CRC not cleared at chunk end");

endmodule

// ===== sv/lmhd_history_ram.sv =====
// Single-clock history memory: one write port and one registered read port.
// Stand-alone; contents are undefined until written.
module lmhd_history_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read at the address being written returns the old byte.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lmhd_crc_unit.sv =====
// Running CRC-32 register over emitted bytes, with clear at chunk end.
// Depends on lmhd_pkg for crc_ctl_t and crc_byte.
module lmhd_crc_unit import lmhd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  crc_ctl_t    ctl,
  output logic [31:0] crc,
  output logic [31:0] crc_upd
);

  assign crc_upd = crc_byte(crc, ctl.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= 32'd0;
    end else if (ctl.clr) begin
      crc <= 32'd0;
    end else if (ctl.upd) begin
      crc <= crc_upd;
    end
  end

endmodule

// ===== tb/sv/literal_match_history_decoder_unit_test.sv =====
// Self-checking bench for literal_match_history_decoder_unit: drives token streams, predicts
// the rebuilt bytes and CRC-32 in a behavioral model and checks every result transfer.
// Depends on lmhd_pkg for the kind and status codes and the CRC polynomial.
module literal_match_history_decoder_unit_test;
  import lmhd_pkg::*;

  localparam int HIST_DEPTH   = 65536;
  localparam int MAX_COPY     = 64;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE_TICKS = 10;

  // The fourth kind code has no name in the package; the block drops such tokens.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One token as the block sees it; kind goes on s_tuser and the other fields pack into s_tdata.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [6:0]  match_length;
    logic [15:0] match_offset;
    logic [31:0] stored_checksum;
  } token_t;

  // A token waiting for the driver. When crc_from_model is set, the driver replaces the
  // stored checksum with the predicted CRC at the moment the token goes on the bus, so a
  // chunk end can be made to match.
  typedef struct {
    token_t tok;
    bit     crc_from_model;
  } pending_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [1:0]  status;
    logic [31:0] running_checksum;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  literal_match_history_decoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Behavioral copy of the decoder state. It is advanced only when a token transfer is
  // seen on the input, so it always reflects what the block has accepted so far.
  logic [7:0]  hist_bytes [HIST_DEPTH];
  logic [15:0] hist_wr_ptr  = '0;
  int unsigned hist_filled  = 0;
  logic [31:0] chunk_crc    = '0;
  logic        check_enable = 1'b1;

  pending_t token_backlog[$];
  result_t  decoded_due[$];
  token_t   on_bus;

  // Bytes that the queued tokens will have produced, used only to aim generated offsets.
  int bytes_so_far = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count    = 0;
  int cycle_count   = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Reflected CRC-32, one bit at a time with the feedback taken before the shift.
  function automatic logic [31:0] crc32_advance(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic token_t make_token(input logic [1:0] kind, input logic [7:0] data,
                                        input logic [6:0] len, input logic [15:0] offset,
                                        input logic [31:0] stored);
    token_t t;
    t.kind            = kind;
    t.data_byte       = data;
    t.match_length    = len;
    t.match_offset    = offset;
    t.stored_checksum = stored;
    return t;
  endfunction

  task automatic append_history(input logic [7:0] b);
    hist_bytes[hist_wr_ptr] = b;
    hist_wr_ptr = hist_wr_ptr + 16'd1;
    if (hist_filled < HIST_DEPTH) begin
      hist_filled++;
    end
    chunk_crc = crc32_advance(chunk_crc, b);
  endtask

  // Works out every result that one accepted token causes and queues them in order.
  task automatic decode_token(input token_t t);
    result_t     r;
    int unsigned copy_len;
    logic [15:0] src;
    logic [7:0]  b;
    r = '0;
    r.last = 1'b1;
    case (t.kind)
      KIND_LIT: begin
        append_history(t.data_byte);
        r.out_byte         = t.data_byte;
        r.byte_valid       = 1'b1;
        r.status           = STAT_OK;
        r.running_checksum = chunk_crc;
        decoded_due.push_back(r);
      end
      KIND_MATCH: begin
        // The offset is checked first, so a bad offset wins over a zero length.
        if (t.match_offset == '0 || t.match_offset > hist_filled) begin
          r.status           = STAT_BAD_OFFSET;
          r.running_checksum = chunk_crc;
          decoded_due.push_back(r);
        end else if (t.match_length == '0) begin
          r.status           = STAT_ZERO_LEN;
          r.running_checksum = chunk_crc;
          decoded_due.push_back(r);
        end else begin
          copy_len = (t.match_length > MAX_COPY) ? MAX_COPY : t.match_length;
          // Each copied byte lands in the history before the next read, which is what makes
          // a short offset repeat its pattern.
          for (int unsigned i = 0; i < copy_len; i++) begin
            src = hist_wr_ptr - t.match_offset;
            b   = hist_bytes[src];
            append_history(b);
            r.out_byte         = b;
            r.byte_valid       = 1'b1;
            r.last             = (i + 1 == copy_len);
            r.status           = STAT_OK;
            r.running_checksum = chunk_crc;
            decoded_due.push_back(r);
          end
        end
      end
      KIND_END: begin
        r.status = (check_enable && chunk_crc != t.stored_checksum) ? STAT_CRC_MISMATCH
                                                                    : STAT_OK;
        r.running_checksum = chunk_crc;
        decoded_due.push_back(r);
        chunk_crc = '0;
      end
      default: begin
      end
    endcase
  endtask

  // Input driver. A transfer seen at this edge is decoded first, so a token whose checksum
  // comes from the model sees the CRC after every earlier token.
  always @(posedge clk) begin : drive_tokens
    pending_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_token(on_bus);
      end
      if (!s_tvalid || s_tready) begin
        if (token_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = token_backlog.pop_front();
          if (nxt.crc_from_model) begin
            nxt.tok.stored_checksum = chunk_crc;
          end
          on_bus   = nxt.tok;
          s_tdata  <= {1'b0, nxt.tok.stored_checksum, nxt.tok.match_offset,
                       nxt.tok.match_length, nxt.tok.data_byte};
          s_tuser  <= nxt.tok.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each transfer is checked against the oldest prediction, field by field.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.out_byte         = m_tdata[7:0];
        got.running_checksum = m_tdata[39:8];
        got.byte_valid       = m_tuser[0];
        got.status           = m_tuser[2:1];
        got.last             = m_tlast;
        if (decoded_due.size() == 0) begin
          $error("unexpected result transfer: out_byte %0h status %0h",
                 got.out_byte, got.status);
          fail_count++;
        end else begin
          want = decoded_due.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            fail_count++;
          end
          if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0h, got %0h", want.byte_valid, got.byte_valid);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0h, got %0h", want.last, got.last);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0h, got %0h", want.status, got.status);
            fail_count++;
          end
          if (got.running_checksum !== want.running_checksum) begin
            $error("running_checksum: expected %0h, got %0h",
                   want.running_checksum, got.running_checksum);
            fail_count++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("literal_match_history_decoder_unit verification failed");
      $finish;
    end
  end

  // Queues a token and keeps a running count of the bytes the stream will have produced,
  // so that generated offsets can be aimed inside the filled part of the history.
  task automatic queue_token(input token_t t, input bit crc_from_model);
    pending_t p;
    p.tok            = t;
    p.crc_from_model = crc_from_model;
    token_backlog.push_back(p);
    if (t.kind == KIND_LIT) begin
      bytes_so_far++;
    end else if (t.kind == KIND_MATCH && t.match_offset != '0 &&
                 t.match_offset <= bytes_so_far && t.match_length != '0) begin
      bytes_so_far += (t.match_length > MAX_COPY) ? MAX_COPY : t.match_length;
    end
    if (bytes_so_far > HIST_DEPTH) begin
      bytes_so_far = HIST_DEPTH;
    end
  endtask

  // Mostly well-formed traffic: literals and matches that reach into the filled history,
  // chunk ends with right or random checksums, plus broken matches and dropped tokens.
  task automatic queue_random_tokens(input int count);
    token_t t;
    int     made;
    int     pick;
    int     reach;
    bit     from_model;
    made = 0;
    while (made < count) begin
      t = make_token(2'($urandom), 8'($urandom), 7'($urandom), 16'($urandom), $urandom);
      from_model = 1'b0;
      pick = $urandom_range(99);
      if (pick < 35 || (pick < 75 && bytes_so_far == 0)) begin
        t.kind = KIND_LIT;
      end else if (pick < 75) begin
        t.kind = KIND_MATCH;
        reach  = (bytes_so_far < 300) ? bytes_so_far : 300;
        t.match_offset = ($urandom_range(3) == 0) ? 16'($urandom_range(bytes_so_far, 1))
                                                  : 16'($urandom_range(reach, 1));
        t.match_length = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 17))
                                                  : 7'($urandom_range(16, 1));
      end else if (pick < 85) begin
        t.kind     = KIND_END;
        from_model = 1'($urandom_range(1));
      end else if (pick < 95) begin
        t.kind = KIND_MATCH;
        case ($urandom_range(2))
          0: t.match_offset = '0;
          1: t.match_offset = 16'($urandom_range(65535, bytes_so_far + 1));
          default: begin
            t.match_length = '0;
            t.match_offset = (bytes_so_far == 0) ? 16'd0
                                                 : 16'($urandom_range(bytes_so_far, 1));
          end
        endcase
      end else begin
        t.kind = KIND_UNUSED;
      end
      queue_token(t, from_model);
      if (t.kind != KIND_UNUSED) begin
        made++;
      end
    end
  endtask

  // Waits until every queued token has gone and every predicted result
  // has arrived, then lets the block settle; a dropped token leaves no result to wait for.
  task automatic drain_results();
    @(negedge clk);
    while (token_backlog.size() != 0 || s_tvalid || decoded_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_crc_check(input logic en);
    cfg_data  <= en;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid    <= 1'b0;
    check_enable = en;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled; check enable still at its reset value.
    send_idle_pct = 18;
    recv_idle_pct = 75;

    // Nothing produced yet, so any offset is out of range.
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd1, 16'd1, 32'h0), 1'b0);
    // An empty chunk has CRC zero, which matches a stored zero.
    queue_token(make_token(KIND_END, 8'h00, 7'd0, 16'd0, 32'h0), 1'b0);
    queue_token(make_token(KIND_LIT, 8'h00, 7'd0, 16'd0, 32'h0), 1'b0);
    // Unused fields set to all ones must not matter.
    queue_token(make_token(KIND_LIT, 8'hFF, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd5, 16'd0, 32'h0), 1'b0);
    queue_token(make_token(KIND_MATCH, 8'hFF, 7'd0, 16'd2, 32'hFFFF_FFFF), 1'b0);
    // Offset out of range and zero length together: the offset error is reported.
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd0, 16'd3, 32'h0), 1'b0);
    // Offset one repeats the last byte across the whole copy.
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd10, 16'd1, 32'h0), 1'b0);
    // Length above the maximum is cut down to it.
    queue_token(make_token(KIND_MATCH, 8'h00, 7'h7F, 16'd2, 32'h0), 1'b0);
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd64, 16'd12, 32'h0), 1'b0);
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd3, 16'hFFFF, 32'h0), 1'b0);
    queue_token(make_token(KIND_UNUSED, 8'hFF, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
    queue_token(make_token(KIND_LIT, 8'hA5, 7'h55, 16'hAAAA, 32'h5555_AAAA), 1'b0);
    queue_token(make_token(KIND_END, 8'h00, 7'd0, 16'd0, 32'h0), 1'b1);
    // The history survives a chunk end even though the CRC restarts.
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd4, 16'd5, 32'h0), 1'b0);
    queue_token(make_token(KIND_END, 8'hFF, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
    queue_token(make_token(KIND_END, 8'h00, 7'd0, 16'd0, 32'h0), 1'b0);
    queue_token(make_token(KIND_MATCH, 8'h00, 7'd64, 16'd64, 32'h0), 1'b0);
    queue_token(make_token(KIND_LIT, 8'h5A, 7'd0, 16'd0, 32'h0), 1'b0);
    queue_token(make_token(KIND_END, 8'h00, 7'd0, 16'd0, 32'h1234_5678), 1'b0);
    drain_results();

    // Comparison off: a wrong stored checksum must still give status ok.
    write_crc_check(1'b0);
    queue_random_tokens(60);
    drain_results();

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 75;
    recv_idle_pct = 18;
    write_crc_check(1'b1);
    queue_random_tokens(60);
    drain_results();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_crc_check(1'b0);
    queue_random_tokens(30);
    drain_results();
    write_crc_check(1'b1);
    queue_random_tokens(30);
    drain_results();

    if (fail_count == 0) begin
      $display("literal_match_history_decoder_unit verification clean");
    end else begin
      $display("literal_match_history_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
